[src/gnq_pkg.sv]
// Shared types and constants of the uniform grid neighbor query core.
// Used by every module of the block; depends on nothing.
package gnq_pkg;

    localparam int COORD_W = 16;
    localparam int GROUP_W = 8;
    localparam int COL_W = 7;
    localparam int COLS_W = 8;
    localparam int EPOCH_W = 8;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;
    localparam int CMD_DEPTH = 2;

    localparam int DEF_MAX_COLUMNS = 32;
    localparam int DEF_CELL_CAPACITY = 8;
    localparam int DEF_MAX_GROUPS = 256;
    localparam int DEF_MAX_EMIT = 64;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] KIND_ACK = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
    localparam logic [1:0] CFG_GRID_COLUMNS = 2'd1;
    localparam logic [1:0] CFG_DOMAIN_EXTENT = 2'd2;
    localparam logic [1:0] CFG_SEARCH_RADIUS = 2'd3;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_QUERY,
        OP_CLEAR,
        OP_REJECT
    } op_t;

    typedef struct packed {
        logic [15:0] cell_size;
        logic [5:0]  grid_columns;
        logic [15:0] domain_extent;
        logic [2:0]  search_radius;
    } cfg_t;

    // One classified operation handed from the front to the back.
    typedef struct packed {
        op_t                  op;
        logic [COL_W-1:0]     x0;
        logic [COL_W-1:0]     x1;
        logic [COL_W-1:0]     y0;
        logic [COL_W-1:0]     y1;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [GROUP_W-1:0]   grp;
        logic                 excl_en;
        logic [GROUP_W-1:0]   excl;
    } cmd_t;

endpackage

[src/uniform_grid_neighbor_query_core.sv]
// Top level of the uniform grid neighbor query core: configuration
// registers, front end, command queue and back end. Depends on gnq_pkg.
//
//  channel   direction  handshake            contents
//  s_        in         s_tvalid/s_tready    operation word
//  m_        out        m_tvalid/m_tready    result word, m_tlast ends an operation
//  cfg_      in         cfg_wr_en            register write, no wait
//
// An insert or query in the front takes two 16-step divisions in the shared
// divider; a clear or rejected query skips them. A query in the back scans
// each cell of the neighborhood and reads each of its points, and a clear
// wipes all MAX_COLUMNS*MAX_COLUMNS cell fills. After reset a clearing pass
// over the cell fill and group tag memories runs before the first command;
// every 255 queries the group tags get a pass over all MAX_GROUPS entries.
// A stalled result output holds the back end, and the two-entry queue lets
// the front keep accepting meanwhile.
module uniform_grid_neighbor_query_core #(
    parameter int MAX_COLUMNS   = gnq_pkg::DEF_MAX_COLUMNS,
    parameter int CELL_CAPACITY = gnq_pkg::DEF_CELL_CAPACITY,
    parameter int MAX_GROUPS    = gnq_pkg::DEF_MAX_GROUPS,
    parameter int MAX_EMIT      = gnq_pkg::DEF_MAX_EMIT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // coord_x, coord_y, group_index, exclude_enable, exclude_index
    input  logic [gnq_pkg::S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // point_x, point_y, point_group, first_of_group
    output logic [gnq_pkg::M_TDATA_W-1:0]  m_tdata,
    // kind, status
    output logic [3:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [15:0]                    cfg_data
);
    gnq_pkg::cfg_t  cfg_reg;
    gnq_pkg::cmd_t  push_cmd;
    gnq_pkg::cmd_t  pop_cmd;
    logic           push_valid;
    logic           push_ready;
    logic           pop_valid;
    logic           pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cell_size <= 16'd16;
            cfg_reg.grid_columns <= 6'd32;
            cfg_reg.domain_extent <= 16'd512;
            cfg_reg.search_radius <= 3'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gnq_pkg::CFG_CELL_SIZE: cfg_reg.cell_size <= cfg_data;
                gnq_pkg::CFG_GRID_COLUMNS: cfg_reg.grid_columns <= cfg_data[5:0];
                gnq_pkg::CFG_DOMAIN_EXTENT: cfg_reg.domain_extent <= cfg_data;
                gnq_pkg::CFG_SEARCH_RADIUS: cfg_reg.search_radius <= cfg_data[2:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    gnq_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk        (aclk),
        .rstn       (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    gnq_cmd_fifo u_fifo (
        .clk        (aclk),
        .rstn       (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    gnq_back #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .CELL_CAPACITY (CELL_CAPACITY),
        .MAX_GROUPS    (MAX_GROUPS),
        .MAX_EMIT      (MAX_EMIT)
    ) u_back (
        .clk       (aclk),
        .rstn      (aresetn),
        .cmd_valid (pop_valid),
        .cmd_pop   (pop),
        .cmd       (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    a_reset_no_result: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == gnq_pkg::KIND_EMPTY |-> m_tlast && !m_tdata[40])
        else $error("empty query result not final or flagged first");
    a_ack_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == gnq_pkg::KIND_ACK |->
            m_tlast && m_tuser[3:2] != gnq_pkg::ST_OUTSIDE && m_tuser[3:2] != gnq_pkg::ST_TRUNC)
        else $error("acknowledge word malformed");
    a_point_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == gnq_pkg::KIND_POINT && !m_tlast |->
            m_tuser[3:2] == gnq_pkg::ST_OK)
        else $error("non-final neighbor word carries a status");
`endif
endmodule

[src/gnq_div.sv]
// Restoring divider, one quotient bit per cycle, for cell position lookup.
// Depends on gnq_pkg for the coordinate width.
module gnq_div (
    input  logic                         clk,
    input  logic                         rstn,
    input  logic                         start,
    input  logic [gnq_pkg::COORD_W-1:0]  dividend,
    input  logic [gnq_pkg::COORD_W-1:0]  divisor,
    output logic                         done,
    output logic [gnq_pkg::COORD_W-1:0]  quotient
);
    localparam int W = gnq_pkg::COORD_W;
    localparam int CW = $clog2(W);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    shifted;
    logic [W:0]    trial;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(W - 1));
            if (start) begin
                rem_reg <= '0;
                quo_reg <= dividend;
                dvs_reg <= divisor;
                cnt_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], ~trial[W]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

[src/gnq_front.sv]
// Front end: accepts input words, finds cell positions and query bounds,
// and hands classified commands on. Depends on gnq_pkg and gnq_div.
module gnq_front #(
    parameter int MAX_COLUMNS = gnq_pkg::DEF_MAX_COLUMNS
) (
    input  logic                           clk,
    input  logic                           rstn,
    input  gnq_pkg::cfg_t                  cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gnq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                     s_tuser,
    output logic                           push_valid,
    input  logic                           push_ready,
    output gnq_pkg::cmd_t                  push_cmd
);
    localparam int CLS = gnq_pkg::COLS_W;
    localparam int COL = gnq_pkg::COL_W;
    localparam int CRD = gnq_pkg::COORD_W;

    typedef enum logic [1:0] {F_IDLE, F_DIVX, F_DIVY, F_PUSH} fstate_t;

    fstate_t          state_reg;
    gnq_pkg::op_t     op_reg;
    logic [CRD-1:0]   cx_reg;
    logic [CRD-1:0]   cy_reg;
    logic [7:0]       grp_reg;
    logic             excl_en_reg;
    logic [7:0]       excl_reg;
    logic [COL-1:0]   px_reg;
    logic [COL-1:0]   py_reg;

    logic             accept;
    logic [1:0]       func;
    logic [CRD-1:0]   in_x;
    logic [CRD-1:0]   in_y;
    logic             outside;
    logic             div_start;
    logic             div_done;
    logic [CRD-1:0]   div_q;
    logic [CRD-1:0]   div_a;
    logic [CRD-1:0]   divisor;
    logic [CLS-1:0]   cols;
    logic [COL-1:0]   pos_clamped;
    logic [CLS-1:0]   rad;
    logic [CLS-1:0]   sum_x;
    logic [CLS-1:0]   sum_y;
    logic [COL-1:0]   xb, xe, yb, ye;

    assign func = s_tuser;
    assign in_x = s_tdata[15:0];
    assign in_y = s_tdata[31:16];
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == F_IDLE);
    assign outside = (in_x > cfg.domain_extent) || (in_y > cfg.domain_extent);

    assign divisor = (cfg.cell_size == '0) ? CRD'(1) : cfg.cell_size;
    always_comb begin
        if (cfg.grid_columns == '0) begin
            cols = CLS'(1);
        end else if (CLS'(cfg.grid_columns) > CLS'(MAX_COLUMNS)) begin
            cols = CLS'(MAX_COLUMNS);
        end else begin
            cols = CLS'(cfg.grid_columns);
        end
    end
    assign pos_clamped = (div_q >= CRD'(cols)) ? COL'(cols - 1'b1) : COL'(div_q);

    assign div_start = (accept && (func == gnq_pkg::FUNC_INSERT ||
                        (func == gnq_pkg::FUNC_QUERY && !outside))) ||
                       (state_reg == F_DIVX && div_done);
    assign div_a = (state_reg == F_IDLE) ? in_x : cy_reg;

    gnq_div u_div (
        .clk      (clk),
        .rstn     (rstn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Neighborhood bounds, clamped to the grid on both ends.
    assign rad = CLS'(cfg.search_radius);
    assign sum_x = CLS'(px_reg) + rad;
    assign sum_y = CLS'(py_reg) + rad;
    assign xb = (CLS'(px_reg) > rad) ? COL'(CLS'(px_reg) - rad) : '0;
    assign yb = (CLS'(py_reg) > rad) ? COL'(CLS'(py_reg) - rad) : '0;
    assign xe = (sum_x >= cols) ? COL'(cols - 1'b1) : COL'(sum_x);
    assign ye = (sum_y >= cols) ? COL'(cols - 1'b1) : COL'(sum_y);

    always_comb begin
        push_cmd.op = op_reg;
        push_cmd.x0 = (op_reg == gnq_pkg::OP_INSERT) ? px_reg : xb;
        push_cmd.y0 = (op_reg == gnq_pkg::OP_INSERT) ? py_reg : yb;
        push_cmd.x1 = xe;
        push_cmd.y1 = ye;
        push_cmd.cx = cx_reg;
        push_cmd.cy = cy_reg;
        push_cmd.grp = grp_reg;
        push_cmd.excl_en = excl_en_reg;
        push_cmd.excl = excl_reg;
    end
    assign push_valid = (state_reg == F_PUSH);

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= F_IDLE;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        cx_reg <= in_x;
                        cy_reg <= in_y;
                        grp_reg <= s_tdata[39:32];
                        excl_en_reg <= s_tdata[40];
                        excl_reg <= s_tdata[48:41];
                        case (func)
                            gnq_pkg::FUNC_INSERT: begin
                                op_reg <= gnq_pkg::OP_INSERT;
                                state_reg <= F_DIVX;
                            end
                            gnq_pkg::FUNC_QUERY: begin
                                op_reg <= outside ? gnq_pkg::OP_REJECT : gnq_pkg::OP_QUERY;
                                state_reg <= outside ? F_PUSH : F_DIVX;
                            end
                            gnq_pkg::FUNC_CLEAR: begin
                                op_reg <= gnq_pkg::OP_CLEAR;
                                state_reg <= F_PUSH;
                            end
                            default: state_reg <= F_IDLE;
                        endcase
                    end
                end
                F_DIVX: begin
                    if (div_done) begin
                        px_reg <= pos_clamped;
                        state_reg <= F_DIVY;
                    end
                end
                F_DIVY: begin
                    if (div_done) begin
                        py_reg <= pos_clamped;
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (push_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

[src/gnq_cmd_fifo.sv]
// Two-entry command queue between the front end and the back end.
// Depends on gnq_pkg for the command type.
module gnq_cmd_fifo (
    input  logic           clk,
    input  logic           rstn,
    input  logic           push_valid,
    output logic           push_ready,
    input  gnq_pkg::cmd_t  push_cmd,
    output logic           pop_valid,
    input  logic           pop,
    output gnq_pkg::cmd_t  pop_cmd
);
    localparam int D = gnq_pkg::CMD_DEPTH;
    localparam int PW = $clog2(D);

    gnq_pkg::cmd_t  entry_reg [D];
    logic [PW-1:0]  wptr_reg;
    logic [PW-1:0]  rptr_reg;
    logic [PW:0]    count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != (PW+1)'(D));
    assign pop_valid = (count_reg != '0);
    assign do_push = push_valid && push_ready;
    assign do_pop = pop && pop_valid;
    assign pop_cmd = entry_reg[rptr_reg];

    always_ff @(posedge clk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
        if (!rstn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) wptr_reg <= wptr_reg + 1'b1;
            if (do_pop) rptr_reg <= rptr_reg + 1'b1;
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

[src/gnq_back.sv]
// Back end: cell fill, point and group tag memories, insert, clear and the
// neighborhood scan, with the result register. Depends on gnq_pkg.
module gnq_back #(
    parameter int MAX_COLUMNS   = gnq_pkg::DEF_MAX_COLUMNS,
    parameter int CELL_CAPACITY = gnq_pkg::DEF_CELL_CAPACITY,
    parameter int MAX_GROUPS    = gnq_pkg::DEF_MAX_GROUPS,
    parameter int MAX_EMIT      = gnq_pkg::DEF_MAX_EMIT
) (
    input  logic                           clk,
    input  logic                           rstn,
    input  logic                           cmd_valid,
    output logic                           cmd_pop,
    input  gnq_pkg::cmd_t                  cmd,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gnq_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [3:0]                     m_tuser,
    output logic                           m_tlast
);
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int NUM_CELLS = MAX_COLUMNS * MAX_COLUMNS;
    localparam int CLW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int FW = $clog2(CELL_CAPACITY + 1);
    localparam int AW = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int NUM_PTS = NUM_CELLS * CELL_CAPACITY;
    localparam int PW = (NUM_PTS > 1) ? $clog2(NUM_PTS) : 1;
    localparam int GW = $clog2(MAX_GROUPS);
    localparam int EW = $clog2(MAX_EMIT + 1);
    localparam int SWEEP = (NUM_CELLS > MAX_GROUPS) ? NUM_CELLS : MAX_GROUPS;
    localparam int SWW = $clog2(SWEEP + 1);
    localparam int EPW = gnq_pkg::EPOCH_W;
    localparam int COL = gnq_pkg::COL_W;

    typedef enum logic [3:0] {
        B_INIT, B_IDLE, B_DISPATCH, B_INS_WR, B_CLR, B_GCLR, B_CELL,
        B_FILL, B_PT, B_PTW, B_GRP, B_GRPW, B_DONE, B_EMIT
    } bstate_t;

    logic [FW-1:0]  cell_fill_mem [NUM_CELLS];
    logic [39:0]    point_mem [NUM_PTS];
    logic [EPW-1:0] group_tag_mem [MAX_GROUPS];
    logic [GW-1:0]  gmod [256];

    bstate_t        state_reg;
    gnq_pkg::cmd_t  cur_reg;
    logic [SWW-1:0] sweep_reg;
    logic [COL-1:0] xi_reg;
    logic [COL-1:0] yi_reg;
    logic [FW-1:0]  a_reg;
    logic [FW-1:0]  fill_reg;
    logic [EPW-1:0] epoch_reg;
    logic [EW-1:0]  cnt_reg;
    logic           trunc_reg;
    logic           hold_valid_reg;
    logic [15:0]    hold_x_reg;
    logic [15:0]    hold_y_reg;
    logic [7:0]     hold_g_reg;
    logic           hold_first_reg;
    logic [1:0]     res_kind_reg;
    logic [1:0]     res_status_reg;

    logic           m_valid_reg;
    logic [1:0]     m_kind_reg;
    logic [1:0]     m_status_reg;
    logic [15:0]    m_x_reg;
    logic [15:0]    m_y_reg;
    logic [7:0]     m_g_reg;
    logic           m_first_reg;
    logic           m_last_reg;

    logic [FW-1:0]  cf_rd;
    logic [39:0]    pt_rd;
    logic [EPW-1:0] tag_rd;
    logic           cf_we, pt_we, gt_we;
    logic [CLW-1:0] cf_wa;
    logic [FW-1:0]  cf_wd;
    logic [GW-1:0]  gt_wa;
    logic [EPW-1:0] gt_wd;
    logic [CLW-1:0] cell_idx;
    logic [PW-1:0]  pt_ra;
    logic [PW-1:0]  pt_wa;
    logic [GW-1:0]  gidx;
    logic           out_free;
    logic           ins_ok;
    logic           grp_go;
    logic           sweep_end;
    logic           pt_last;
    logic           y_more;
    logic           x_more;
    logic [FW-1:0]  fill_clamped;
    logic [EPW-1:0] epoch_inc;
    logic           m_load;

    // Group index reduced into the tag memory; a constant table.
    always_comb begin
        for (int i = 0; i < 256; i++) begin
            gmod[i] = GW'(i % MAX_GROUPS);
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign cell_idx = CLW'(CLW'(xi_reg[CW-1:0]) * CLW'(MAX_COLUMNS) + CLW'(yi_reg[CW-1:0]));
    assign pt_ra = PW'(PW'(cell_idx) * PW'(CELL_CAPACITY) + PW'(a_reg[AW-1:0]));
    assign pt_wa = PW'(PW'(cell_idx) * PW'(CELL_CAPACITY) + PW'(cf_rd[AW-1:0]));
    assign gidx = gmod[pt_rd[39:32]];
    assign ins_ok = (cf_rd < FW'(CELL_CAPACITY));
    assign grp_go = !hold_valid_reg || out_free;
    assign sweep_end = (sweep_reg == SWW'(SWEEP - 1));
    assign pt_last = ({1'b0, a_reg} + 1'b1) >= {1'b0, fill_reg};
    assign y_more = yi_reg < cur_reg.y1;
    assign x_more = xi_reg < cur_reg.x1;
    assign fill_clamped = (cf_rd > FW'(CELL_CAPACITY)) ? FW'(CELL_CAPACITY) : cf_rd;
    assign epoch_inc = epoch_reg + 1'b1;
    assign cmd_pop = (state_reg == B_IDLE) && cmd_valid;

    // A new result word is loaded into the output register this cycle.
    assign m_load = ((state_reg == B_INS_WR || state_reg == B_DONE || state_reg == B_EMIT)
                     && out_free) ||
                    (state_reg == B_GRPW && grp_go && hold_valid_reg);

    always_comb begin
        cf_we = 1'b0;
        cf_wa = cell_idx;
        cf_wd = cf_rd + 1'b1;
        pt_we = 1'b0;
        gt_we = 1'b0;
        gt_wa = gidx;
        gt_wd = epoch_reg;
        case (state_reg)
            B_INIT: begin
                cf_we = (32'(sweep_reg) < NUM_CELLS);
                cf_wa = sweep_reg[CLW-1:0];
                cf_wd = '0;
                gt_we = (32'(sweep_reg) < MAX_GROUPS);
                gt_wa = sweep_reg[GW-1:0];
                gt_wd = '0;
            end
            B_CLR: begin
                cf_we = 1'b1;
                cf_wa = sweep_reg[CLW-1:0];
                cf_wd = '0;
            end
            B_GCLR: begin
                gt_we = 1'b1;
                gt_wa = sweep_reg[GW-1:0];
                gt_wd = '0;
            end
            B_INS_WR: begin
                cf_we = out_free && ins_ok;
                pt_we = out_free && ins_ok;
            end
            B_GRPW: gt_we = grp_go;
            default: cf_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk) begin
        if (cf_we) cell_fill_mem[cf_wa] <= cf_wd;
        cf_rd <= cell_fill_mem[cell_idx];
    end

    always_ff @(posedge clk) begin
        if (pt_we) point_mem[pt_wa] <= {cur_reg.grp, cur_reg.cy, cur_reg.cx};
        pt_rd <= point_mem[pt_ra];
    end

    always_ff @(posedge clk) begin
        if (gt_we) group_tag_mem[gt_wa] <= gt_wd;
        tag_rd <= group_tag_mem[gidx];
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= B_INIT;
            sweep_reg <= '0;
            epoch_reg <= EPW'(1);
            m_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_INIT: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_end) state_reg <= B_IDLE;
                end
                B_IDLE: begin
                    if (cmd_valid) begin
                        cur_reg <= cmd;
                        xi_reg <= cmd.x0;
                        yi_reg <= cmd.y0;
                        state_reg <= B_DISPATCH;
                    end
                end
                B_DISPATCH: begin
                    sweep_reg <= '0;
                    case (cur_reg.op)
                        gnq_pkg::OP_INSERT: state_reg <= B_INS_WR;
                        gnq_pkg::OP_CLEAR: state_reg <= B_CLR;
                        gnq_pkg::OP_QUERY: begin
                            cnt_reg <= '0;
                            trunc_reg <= 1'b0;
                            hold_valid_reg <= 1'b0;
                            epoch_reg <= epoch_inc;
                            // A wrapped tag would alias old queries: wipe the tags first.
                            state_reg <= (epoch_inc == '0) ? B_GCLR : B_CELL;
                        end
                        default: begin
                            res_kind_reg <= gnq_pkg::KIND_EMPTY;
                            res_status_reg <= gnq_pkg::ST_OUTSIDE;
                            state_reg <= B_EMIT;
                        end
                    endcase
                end
                B_INS_WR: begin
                    if (out_free) begin
                        m_kind_reg <= gnq_pkg::KIND_ACK;
                        m_status_reg <= ins_ok ? gnq_pkg::ST_OK : gnq_pkg::ST_FULL;
                        m_x_reg <= '0;
                        m_y_reg <= '0;
                        m_g_reg <= '0;
                        m_first_reg <= 1'b0;
                        m_last_reg <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                end
                B_CLR: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == SWW'(NUM_CELLS - 1)) begin
                        res_kind_reg <= gnq_pkg::KIND_ACK;
                        res_status_reg <= gnq_pkg::ST_OK;
                        state_reg <= B_EMIT;
                    end
                end
                B_GCLR: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == SWW'(MAX_GROUPS - 1)) begin
                        epoch_reg <= EPW'(1);
                        state_reg <= B_CELL;
                    end
                end
                B_CELL: state_reg <= B_FILL;
                B_FILL: begin
                    fill_reg <= fill_clamped;
                    a_reg <= '0;
                    if (fill_clamped != '0) begin
                        state_reg <= B_PT;
                    end else if (y_more) begin
                        yi_reg <= yi_reg + 1'b1;
                        state_reg <= B_CELL;
                    end else if (x_more) begin
                        xi_reg <= xi_reg + 1'b1;
                        yi_reg <= cur_reg.y0;
                        state_reg <= B_CELL;
                    end else begin
                        state_reg <= B_DONE;
                    end
                end
                B_PT: state_reg <= B_PTW;
                B_PTW: begin
                    if (cur_reg.excl_en && pt_rd[39:32] == cur_reg.excl) begin
                        if (!pt_last) begin
                            a_reg <= a_reg + 1'b1;
                            state_reg <= B_PT;
                        end else if (y_more) begin
                            yi_reg <= yi_reg + 1'b1;
                            state_reg <= B_CELL;
                        end else if (x_more) begin
                            xi_reg <= xi_reg + 1'b1;
                            yi_reg <= cur_reg.y0;
                            state_reg <= B_CELL;
                        end else begin
                            state_reg <= B_DONE;
                        end
                    end else if (cnt_reg == EW'(MAX_EMIT)) begin
                        trunc_reg <= 1'b1;
                        state_reg <= B_DONE;
                    end else begin
                        state_reg <= B_GRP;
                    end
                end
                B_GRP: state_reg <= B_GRPW;
                B_GRPW: begin
                    if (grp_go) begin
                        // The held point is not the last one: send it on now.
                        if (hold_valid_reg) begin
                            m_kind_reg <= gnq_pkg::KIND_POINT;
                            m_status_reg <= gnq_pkg::ST_OK;
                            m_x_reg <= hold_x_reg;
                            m_y_reg <= hold_y_reg;
                            m_g_reg <= hold_g_reg;
                            m_first_reg <= hold_first_reg;
                            m_last_reg <= 1'b0;
                        end
                        hold_valid_reg <= 1'b1;
                        hold_x_reg <= pt_rd[15:0];
                        hold_y_reg <= pt_rd[31:16];
                        hold_g_reg <= pt_rd[39:32];
                        hold_first_reg <= (tag_rd != epoch_reg);
                        cnt_reg <= cnt_reg + 1'b1;
                        if (!pt_last) begin
                            a_reg <= a_reg + 1'b1;
                            state_reg <= B_PT;
                        end else if (y_more) begin
                            yi_reg <= yi_reg + 1'b1;
                            state_reg <= B_CELL;
                        end else if (x_more) begin
                            xi_reg <= xi_reg + 1'b1;
                            yi_reg <= cur_reg.y0;
                            state_reg <= B_CELL;
                        end else begin
                            state_reg <= B_DONE;
                        end
                    end
                end
                B_DONE: begin
                    if (out_free) begin
                        m_last_reg <= 1'b1;
                        m_kind_reg <= hold_valid_reg ? gnq_pkg::KIND_POINT : gnq_pkg::KIND_EMPTY;
                        m_status_reg <= trunc_reg ? gnq_pkg::ST_TRUNC : gnq_pkg::ST_OK;
                        m_x_reg <= hold_valid_reg ? hold_x_reg : '0;
                        m_y_reg <= hold_valid_reg ? hold_y_reg : '0;
                        m_g_reg <= hold_valid_reg ? hold_g_reg : '0;
                        m_first_reg <= hold_valid_reg && hold_first_reg;
                        hold_valid_reg <= 1'b0;
                        state_reg <= B_IDLE;
                    end
                end
                B_EMIT: begin
                    if (out_free) begin
                        m_kind_reg <= res_kind_reg;
                        m_status_reg <= res_status_reg;
                        m_x_reg <= '0;
                        m_y_reg <= '0;
                        m_g_reg <= '0;
                        m_first_reg <= 1'b0;
                        m_last_reg <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {7'd0, m_first_reg, m_g_reg, m_y_reg, m_x_reg};
    assign m_tuser = {m_status_reg, m_kind_reg};
    assign m_tlast = m_last_reg;
endmodule
